[design/bls_pkg.sv]
// shared types and constants for the block list scheduler
package bls_pkg;
  localparam int TagW = 16;
  localparam int KeyW = 8;

  typedef struct packed {
    logic load_body;
    logic load_term;
    logic build_start;
    logic sched_start;
    logic emit_term;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic build_done;
    logic sched_done;
    logic pick_valid;
    logic term_done;
    logic ovf;
  } ctl_sts_t;
endpackage

[design/block_list_scheduler_core.sv]
// top level of the block list scheduler
// channel | signals                          | direction
// input   | valid ready + instruction fields | in
// output  | out_valid out_ready + out fields | out
// loading: each instruction walks back over the earlier entries (backward def walk).
// emitting: each body word retires its pick and rescans all entries for ready ones; terminators come from the term ram.
// reset rst synchronous clears counters; storage is written before read.
// input stalls outside idle, while an instruction is built or a block is emitted; output stalls hold the word.
module block_list_scheduler_core import bls_pkg::*; #(
  parameter int MAX_INSTRS = 32,
  parameter int MAX_USES = 3,
  parameter int REG_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic [15:0]         tag,
  input  logic                is_terminator,
  input  logic                has_def,
  input  logic [REG_BITS-1:0] def_reg,
  input  logic [1:0]          use_count,
  input  logic [REG_BITS-1:0] use_reg_a,
  input  logic [REG_BITS-1:0] use_reg_b,
  input  logic [REG_BITS-1:0] use_reg_c,
  input  logic [7:0]          latency,
  input  logic [7:0]          cost,
  input  logic                block_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_tag,
  output logic                out_last,
  output logic                overflow
);
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic [TagW-1:0] pick_tag;
  logic pick_last, ovf_w;

  bls_ctrl u_ctrl (
    .clk, .rst, .valid, .ready, .is_terminator, .block_end,
    .out_valid, .out_ready, .out_ovf(ovf_w), .cmd, .sts
  );

  bls_datapath #(.MaxInstrs(MAX_INSTRS), .MaxUses(MAX_USES), .RegBits(REG_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .tag, .has_def, .def_reg, .use_count,
    .use_reg_a, .use_reg_b, .use_reg_c, .latency, .cost, .pick_tag, .pick_last
  );

  assign out_tag  = ovf_w ? '0 : pick_tag;
  assign out_last = ovf_w | pick_last;
  assign overflow = ovf_w;
endmodule

[design/bls_ram.sv]
// generic single-write ram with registered read
module bls_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/bls_datapath.sv]
// storage, dependency build and selection datapath
module bls_datapath import bls_pkg::*; #(
  parameter int MaxInstrs = 32,
  parameter int MaxUses = 3,
  parameter int RegBits = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  input  logic [TagW-1:0]    tag,
  input  logic               has_def,
  input  logic [RegBits-1:0] def_reg,
  input  logic [1:0]         use_count,
  input  logic [RegBits-1:0] use_reg_a,
  input  logic [RegBits-1:0] use_reg_b,
  input  logic [RegBits-1:0] use_reg_c,
  input  logic [KeyW-1:0]    latency,
  input  logic [KeyW-1:0]    cost,
  output logic [TagW-1:0]    pick_tag,
  output logic               pick_last
);
  localparam int IdxW = $clog2(MaxInstrs);
  localparam int CntW = $clog2(MaxInstrs + 1);
  localparam int TotW = CntW + 1;

  // per-entry registers, each read at its own place
  logic [TagW-1:0]    btag [MaxInstrs];
  logic [KeyW-1:0]    blat [MaxInstrs];
  logic [KeyW-1:0]    bcst [MaxInstrs];
  logic               bdv  [MaxInstrs];
  logic [RegBits-1:0] bdr  [MaxInstrs];
  logic [MaxInstrs-1:0] pred [MaxInstrs];  // pred[i][j]: j precedes i
  logic [MaxInstrs-1:0] done_m;
  logic [CntW-1:0] body_count, term_count, term_idx;
  logic [TotW-1:0] emitted;
  logic overflow_seen;

  // per-use scan state: the newest matching definer per use
  logic [IdxW-1:0]    scan;
  logic               scanning;
  logic [MaxInstrs-1:0] edges;
  logic [MaxUses-1:0] found;
  logic [RegBits-1:0] ureg [MaxUses];
  logic [MaxUses-1:0] uval;
  logic               pend_def;
  logic [RegBits-1:0] pend_reg;
  logic [IdxW-1:0]    cur;

  // ready order: sequence number of becoming ready (insertion order)
  logic [TotW+IdxW-1:0] rseq [MaxInstrs];
  logic [MaxInstrs-1:0] rdy;
  logic [TotW+IdxW-1:0] seq_ctr;

  // selection scan over entries
  logic [IdxW-1:0] sel_i;
  logic            selecting;
  logic            have_best;
  logic [IdxW-1:0] best;

  logic [TagW-1:0] tram_rdata;
  logic            term_we;

  assign term_we = cmd.load_term && (term_count < CntW'(MaxInstrs));

  bls_ram #(.Width(TagW), .Depth(MaxInstrs)) u_term (
    .clk(clk), .we(term_we), .waddr(term_count[IdxW-1:0]), .wdata(tag),
    .raddr(term_idx[IdxW-1:0]), .rdata(tram_rdata)
  );

  logic [MaxInstrs-1:0] ready_now;
  always_comb begin
    for (int i = 0; i < MaxInstrs; i++)
      ready_now[i] = (CntW'(i) < body_count) && !done_m[i] && ((pred[i] & ~done_m) == '0);
  end

  // candidate beats best: higher latency, then cost, then earlier ready order
  logic cand_better;
  always_comb begin
    cand_better = 1'b0;
    if (rdy[sel_i]) begin
      if (!have_best) cand_better = 1'b1;
      else if (blat[sel_i] > blat[best]) cand_better = 1'b1;
      else if (blat[sel_i] == blat[best] && bcst[sel_i] > bcst[best]) cand_better = 1'b1;
      else if (blat[sel_i] == blat[best] && bcst[sel_i] == bcst[best] &&
               rseq[sel_i] < rseq[best]) cand_better = 1'b1;
    end
  end

  logic [MaxUses-1:0] hit;
  always_comb begin
    for (int k = 0; k < MaxUses; k++)
      hit[k] = uval[k] && !found[k] && bdv[scan] && (bdr[scan] == ureg[k]);
  end

  logic [TotW-1:0] total;
  assign total = TotW'(body_count) + TotW'(term_count);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      body_count <= '0;
      term_count <= '0;
      overflow_seen <= 1'b0;
      scanning <= 1'b0;
      selecting <= 1'b0;
      done_m <= '0;
      rdy <= '0;
      emitted <= '0;
      term_idx <= '0;
      seq_ctr <= '0;
      have_best <= 1'b0;
    end else begin
      if (cmd.load_term && !term_we) overflow_seen <= 1'b1;
      if (term_we) term_count <= term_count + 1'b1;
      if (cmd.load_body) begin
        if (body_count >= CntW'(MaxInstrs)) begin
          overflow_seen <= 1'b1;
        end else begin
          cur <= body_count[IdxW-1:0];
          btag[body_count[IdxW-1:0]] <= tag;
          blat[body_count[IdxW-1:0]] <= latency;
          bcst[body_count[IdxW-1:0]] <= cost;
          bdv[body_count[IdxW-1:0]] <= (body_count == '0) ? has_def : 1'b0;
          pend_def <= has_def;
          pend_reg <= def_reg;
          for (int k = 0; k < MaxUses; k++) begin
            uval[k] <= (k < 3) && (32'(use_count) > k);
            ureg[k] <= (k == 0) ? use_reg_a : (k == 1) ? use_reg_b : use_reg_c;
          end
          edges <= '0;
          found <= '0;
          scan <= body_count[IdxW-1:0] - 1'b1;
          scanning <= (body_count != '0);
          if (body_count == '0) begin
            pred[0] <= '0;
            bdr[0] <= def_reg;
            body_count <= body_count + 1'b1;
          end
        end
      end
      // walk back one earlier entry per cycle
      if (scanning) begin
        for (int k = 0; k < MaxUses; k++)
          if (hit[k]) found[k] <= 1'b1;
        if (|hit) edges[scan] <= 1'b1;
        if (scan == '0) begin
          scanning <= 1'b0;
          pred[cur] <= edges | ((|hit) ? (MaxInstrs'(1) << scan) : '0);
          bdv[cur] <= pend_def;
          bdr[cur] <= pend_reg;
          body_count <= body_count + 1'b1;
        end
        scan <= scan - 1'b1;
      end
      if (cmd.sched_start || (cmd.build_start && !selecting)) begin
        for (int i = 0; i < MaxInstrs; i++)
          if (ready_now[i] && !rdy[i]) begin
            rdy[i] <= 1'b1;
            rseq[i] <= seq_ctr + (TotW+IdxW)'(i);
          end
        seq_ctr <= seq_ctr + (TotW+IdxW)'(MaxInstrs);
        selecting <= 1'b1;
        sel_i <= '0;
        have_best <= 1'b0;
      end else if (selecting) begin
        if (cand_better) begin
          best <= sel_i;
          have_best <= 1'b1;
        end
        if (sel_i == IdxW'(MaxInstrs - 1)) selecting <= 1'b0;
        else sel_i <= sel_i + 1'b1;
      end
      if (cmd.emit_term) begin
        // pick accepted: retire best
        if (!selecting && have_best) begin
          done_m[best] <= 1'b1;
          rdy[best] <= 1'b0;
          have_best <= 1'b0;
        end else begin
          term_idx <= term_idx + 1'b1;
        end
        emitted <= emitted + 1'b1;
      end
    end
  end

  assign pick_tag  = (have_best && !selecting) ? btag[best] : tram_rdata;
  assign pick_last = (emitted + 1'b1) == total;
  assign sts.build_done = !scanning;
  assign sts.sched_done = !selecting;
  assign sts.pick_valid = have_best;
  assign sts.term_done  = term_idx >= term_count;
  assign sts.ovf        = overflow_seen;

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    body_count <= CntW'(MaxInstrs)) else $error("body count past capacity");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emitted <= total) else $error("more results than entries");
  a_best: assert property (@(posedge clk) disable iff (rst)
    (have_best && !selecting) |-> !done_m[best]) else $error("picked retired entry");
`endif
endmodule

[design/bls_ctrl.sv]
// controller for load, build, schedule and emit phases
module bls_ctrl import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     valid,
  output logic     ready,
  input  logic     is_terminator,
  input  logic     block_end,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_ovf,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BUILD = 6'b000010,
    S_SCAN  = 6'b000100,
    S_BODY  = 6'b001000,
    S_TERM  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;
  state_t state, state_next;
  logic   end_pend, end_pend_next, started;
  logic   acc;

  assign ready = (state == S_IDLE);
  assign acc = valid && ready;

  always_comb begin
    state_next = state;
    end_pend_next = end_pend;
    cmd = '0;
    out_valid = 1'b0;
    out_ovf = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          cmd.load_body = !is_terminator;
          cmd.load_term = is_terminator;
          end_pend_next = block_end;
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        if (sts.build_done) begin
          if (!end_pend) state_next = S_IDLE;
          else if (sts.ovf) state_next = S_WAIT;
          else begin
            cmd.sched_start = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: if (sts.sched_done && !started) state_next = sts.pick_valid ? S_BODY : S_TERM;
      S_BODY: begin
        out_valid = 1'b1;
        // retire first, successors join the ready set on the next rescan
        if (out_ready) begin
          cmd.emit_term = 1'b1;
          state_next = S_BUILD;
        end
      end
      S_TERM: begin
        if (sts.term_done) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.emit_term = 1'b1;
            state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // overflow word, or a wait state for the term ram read
        if (sts.ovf) begin
          out_valid = 1'b1;
          out_ovf = 1'b1;
          if (out_ready) begin
            cmd.clear = 1'b1;
            state_next = S_IDLE;
          end
        end else state_next = S_TERM;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sched_start launches the scan next cycle, so started masks the first status sample after it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      end_pend <= 1'b0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      end_pend <= end_pend_next;
      started <= cmd.sched_start;
    end
  end

`ifndef SYNTHESIS
  a_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("output while loading");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> state == S_IDLE) else $error("clear not idle");
  a_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_body, cmd.load_term, cmd.clear})) else $error("cmd clash");
`endif
endmodule

[tb/sv/block_list_scheduler_core_tb.sv]
// testbench for the block list scheduler: directed blocks, random blocks, overflow
module block_list_scheduler_core_tb;
  import bls_pkg::*;

  localparam int NInstr = 32;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic [15:0] tag;
    logic        term;
    logic        has_def;
    logic [9:0]  def_reg;
    logic [1:0]  nuse;
    logic [9:0]  ua, ub, uc;
    logic [7:0]  lat, cst;
    logic        last;
  } instr_t;

  typedef struct {
    logic [15:0] tag;
    logic        last;
    logic        ovf;
  } sched_word_t;

  logic clk = 0, rst = 1;
  logic valid = 0, out_ready = 0;
  logic ready, out_valid;
  logic [15:0] tag = 0;
  logic is_terminator = 0, has_def = 0, block_end = 0;
  logic [9:0] def_reg = 0, use_reg_a = 0, use_reg_b = 0, use_reg_c = 0;
  logic [1:0] use_count = 0;
  logic [7:0] latency = 0, cost = 0;
  logic [15:0] out_tag;
  logic out_last, overflow;

  block_list_scheduler_core dut (.*);

  initial forever #4 clk = ~clk;

  // predictor state for the block being loaded
  instr_t      blk_body[$];
  logic [15:0] blk_terms[$];
  logic        blk_ovf;
  sched_word_t sched_q[$];
  int errors = 0;
  int n_items = 0, n_words = 0, n_blocks = 0;
  bit quiet = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, n_words);
  endtask

  // list schedule of the finished block, appended to the expected queue
  task automatic schedule_block();
    bit          succ[NInstr][NInstr];
    int          preds[NInstr];
    int          rdy[$];
    int          nb, total, n, pos, best, c;
    logic [9:0]  u[3];
    sched_word_t w;
    nb = blk_body.size();
    total = nb + blk_terms.size();
    n = 0;
    if (blk_ovf) begin
      w.tag = 0; w.last = 1; w.ovf = 1;
      sched_q = {sched_q, w};
    end else begin
      foreach (preds[i]) preds[i] = 0;
      foreach (succ[i, j]) succ[i][j] = 0;
      for (int i = 0; i < nb; i++) begin
        u[0] = blk_body[i].ua; u[1] = blk_body[i].ub; u[2] = blk_body[i].uc;
        for (int k = 0; k < blk_body[i].nuse; k++)
          for (int j = i - 1; j >= 0; j--)
            if (blk_body[j].has_def && blk_body[j].def_reg == u[k]) begin
              if (!succ[j][i]) begin
                succ[j][i] = 1;
                preds[i]++;
              end
              break;
            end
      end
      for (int i = 0; i < nb; i++) if (preds[i] == 0) rdy = {rdy, i};
      while (rdy.size() > 0) begin
        pos = 0;
        best = rdy[0];
        for (int i = 1; i < rdy.size(); i++) begin
          c = rdy[i];
          if (blk_body[c].lat > blk_body[best].lat ||
              (blk_body[c].lat == blk_body[best].lat && blk_body[c].cst > blk_body[best].cst)) begin
            best = c;
            pos = i;
          end
        end
        rdy.delete(pos);
        n++;
        w.tag = blk_body[best].tag; w.last = (n == total); w.ovf = 0;
        sched_q = {sched_q, w};
        for (int s = 0; s < nb; s++)
          if (succ[best][s]) begin
            preds[s]--;
            if (preds[s] == 0) rdy = {rdy, s};
          end
      end
      foreach (blk_terms[i]) begin
        n++;
        w.tag = blk_terms[i]; w.last = (n == total); w.ovf = 0;
        sched_q = {sched_q, w};
      end
    end
    blk_body.delete();
    blk_terms.delete();
    blk_ovf = 0;
    n_blocks++;
  endtask

  // valid stays high into the next word unless an idle gap is taken
  task automatic send_instr(input instr_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    valid <= 1;
    tag <= it.tag; is_terminator <= it.term; has_def <= it.has_def;
    def_reg <= it.def_reg; use_count <= it.nuse;
    use_reg_a <= it.ua; use_reg_b <= it.ub; use_reg_c <= it.uc;
    latency <= it.lat; cost <= it.cst; block_end <= it.last;
    do @(posedge clk); while (!ready);
    n_items++;
    if (it.term) begin
      if (blk_terms.size() >= NInstr) blk_ovf = 1;
      else blk_terms = {blk_terms, it.tag};
    end else begin
      if (blk_body.size() >= NInstr) blk_ovf = 1;
      else blk_body = {blk_body, it};
    end
    if (it.last) schedule_block();
  endtask

  // random instruction; registers drawn from a small pool when pool > 0 so edges form
  function automatic instr_t rand_instr(input bit term, input bit last, input int pool);
    instr_t it;
    it.tag = 16'($urandom); it.term = term; it.has_def = $urandom_range(0, 3) != 0;
    it.def_reg = (pool > 0) ? 10'($urandom_range(0, pool)) : 10'($urandom);
    it.nuse = 2'($urandom);
    it.ua = (pool > 0) ? 10'($urandom_range(0, pool)) : 10'($urandom);
    it.ub = (pool > 0) ? 10'($urandom_range(0, pool)) : 10'($urandom);
    it.uc = (pool > 0) ? 10'($urandom_range(0, pool)) : 10'($urandom);
    it.lat = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    it.cst = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    it.last = last;
    return it;
  endfunction

  task automatic wait_drained();
    valid <= 0;
    do @(posedge clk); while (sched_q.size() > 0);
  endtask

  task automatic test_directed();
    instr_t it;
    // lone body instruction, extreme fields
    it = '{16'hffff, 0, 1, 10'h3ff, 2'd3, 10'h3ff, 10'h3ff, 10'h3ff, 8'hff, 8'hff, 1};
    send_instr(it);
    // lone terminator
    it = '{16'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1};
    send_instr(it);
    // chain with repeated use, plus tie on latency broken by cost
    it = '{16'h0001, 0, 1, 10'd5, 0, 0, 0, 0, 8'd1, 8'd0, 0}; send_instr(it);
    it = '{16'h0002, 0, 1, 10'd6, 2'd2, 10'd5, 10'd5, 0, 8'd9, 8'd1, 0}; send_instr(it);
    it = '{16'h0003, 0, 0, 0, 2'd3, 10'd6, 10'd5, 10'd6, 8'd9, 8'd2, 0}; send_instr(it);
    it = '{16'h0004, 0, 0, 0, 0, 0, 0, 0, 8'd9, 8'd2, 0}; send_instr(it);
    it = '{16'h00aa, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_instr(it);
    // redefinition: later use must see the newest definer
    it = '{16'h0005, 0, 1, 10'd5, 1, 10'd6, 0, 0, 8'd0, 8'd0, 0}; send_instr(it);
    it = '{16'h0006, 0, 0, 0, 1, 10'd5, 0, 0, 8'd200, 8'd0, 0}; send_instr(it);
    it = '{16'h00bb, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1}; send_instr(it);
    wait_drained();
  endtask

  task automatic test_capacity();
    // full block of body and terminators, then one too many of each kind
    for (int i = 0; i < NInstr; i++) send_instr(rand_instr(0, 0, 7));
    for (int i = 0; i < NInstr; i++) send_instr(rand_instr(1, i == NInstr - 1, 7));
    for (int i = 0; i <= NInstr; i++) send_instr(rand_instr(0, i == NInstr, 7));
    for (int i = 0; i <= NInstr; i++) send_instr(rand_instr(1, i == NInstr, 7));
  endtask

  task automatic test_random(input int blocks);
    int len;
    for (int b = 0; b < blocks; b++) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_instr(rand_instr($urandom_range(0, 4) == 0, i == len - 1,
                              ($urandom_range(0, 4) == 0) ? 0 : 5));
      if (b == 1) wait_drained();
    end
  endtask

  // output side: random back-pressure and checking
  always @(posedge clk) begin
    sched_word_t w;
    if (rst) out_ready <= 0;
    else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (sched_q.size() == 0) begin
          report("unexpected word", out_tag, 16'h0000);
        end else begin
          w = sched_q.pop_front();
          if (out_tag !== w.tag) report("out_tag", out_tag, w.tag);
          if (out_last !== w.last) report("out_last", 16'(out_last), 16'(w.last));
          if (overflow !== w.ovf) report("overflow", 16'(overflow), 16'(w.ovf));
        end
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    blk_ovf = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random(3);
    quiet = 1;
    test_random(2);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d instructions in %0d blocks, %0d scheduled words checked",
             n_items, n_blocks, n_words);
    if (errors == 0 && sched_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
